// ===== rtl/core/ofod_pkg.sv =====
`default_nettype none

package ofod_pkg;

    localparam int FIELD_W      = 64;
    localparam int RECORD_WORDS = 7;
    localparam int RECORD_BYTES = 8 * 7;
    localparam int RECORD_W     = RECORD_BYTES * 8;
    localparam int BYTE_CNT_W   = $clog2(RECORD_BYTES);
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [FIELD_W-1:0] FNV_BASIS  = 64'hCBF29CE484222325;
    localparam logic [FIELD_W-1:0] GOLDEN_MIX = 64'h9E3779B97F4A7C15;
    localparam logic [31:0]        GOLDEN_LO  = GOLDEN_MIX[31:0];
    localparam logic [31:0]        GOLDEN_HI  = GOLDEN_MIX[63:32];

    typedef struct packed {
        logic [RECORD_W-1:0] record;
        logic                is_final;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } q_head_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HASH,
        ST_ACC,
        ST_MUL_LL,
        ST_MUL_HL,
        ST_MUL_LH,
        ST_DONE
    } back_state_t;

    // one fnv-1a byte step; prime is 2^40 + 0x1b3, done as shifts and adds
    function automatic logic [FIELD_W-1:0] fnv_step(input logic [FIELD_W-1:0] h,
                                                    input logic [7:0] b);
        logic [FIELD_W-1:0] x;
        x = h ^ {56'b0, b};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ofod_front.sv =====
`default_nettype none

module ofod_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 obs_valid,
    output logic                      obs_ready,
    input  wire logic [63:0]          subject_id,
    input  wire logic [63:0]          subject_generation,
    input  wire logic [63:0]          served,
    input  wire logic [63:0]          unserved_run,
    input  wire logic [63:0]          below_floor_run,
    input  wire logic [63:0]          priority_ref,
    input  wire logic [63:0]          qos_ref,
    input  wire logic                 final_item,
    input  wire logic                 pop,
    output ofod_pkg::q_head_t         head
);
    import ofod_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t             q_mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push;
    item_t             in_item;

    // subject_id lands in the low bytes so the back end shifts out byte 0 first
    always_comb
    begin
        in_item.record   = {qos_ref, priority_ref, below_floor_run, unserved_run,
                            served, subject_generation, subject_id};
        in_item.is_final = final_item;
    end

    assign obs_ready  = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign push       = obs_valid && obs_ready;
    assign head.valid = (count_reg != '0);
    assign head.item  = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/ofod_back.sv =====
`default_nettype none

module ofod_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire ofod_pkg::q_head_t head,
    output logic                  pop,
    output logic                  digest_valid,
    input  wire logic             digest_ready,
    output logic [63:0]           set_digest
);
    import ofod_pkg::*;

    back_state_t            state_reg, state_next;
    logic [BYTE_CNT_W-1:0]  byte_cnt_reg, byte_cnt_next;
    logic [RECORD_W-1:0]    shift_reg, shift_next;
    logic [FIELD_W-1:0]     hash_reg, hash_next;
    logic                   final_reg, final_next;
    logic [FIELD_W-1:0]     hash_sum_reg, hash_sum_next;
    logic [FIELD_W-1:0]     hash_xor_reg, hash_xor_next;
    logic [FIELD_W-1:0]     mul_a_reg, mul_a_next;
    logic [FIELD_W-1:0]     mix_reg, mix_next;
    logic [FIELD_W-1:0]     prod_reg, prod_next;
    logic                   digest_valid_reg, digest_valid_next;
    logic [FIELD_W-1:0]     set_digest_reg, set_digest_next;

    logic [31:0]            mul_x, mul_y;
    logic [63:0]            mul_p;
    logic                   start;
    logic [FIELD_W-1:0]     sum_new, xor_new;

    // shared 32x32 unit for the low half of sum * golden constant
    assign mul_p = mul_x * mul_y;

    assign sum_new = hash_sum_reg + hash_reg;
    assign xor_new = hash_xor_reg ^ hash_reg;

    always_comb
    begin
        state_next        = state_reg;
        byte_cnt_next     = byte_cnt_reg;
        shift_next        = shift_reg;
        hash_next         = hash_reg;
        final_next        = final_reg;
        hash_sum_next     = hash_sum_reg;
        hash_xor_next     = hash_xor_reg;
        mul_a_next        = mul_a_reg;
        mix_next          = mix_reg;
        prod_next         = prod_reg;
        digest_valid_next = digest_valid_reg;
        set_digest_next   = set_digest_reg;
        mul_x             = mul_a_reg[31:0];
        mul_y             = GOLDEN_LO;
        start             = 1'b0;

        if (digest_valid_reg && digest_ready)
        begin
            digest_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                start = head.valid;
            end
            ST_HASH:
            begin
                hash_next  = fnv_step(hash_reg, shift_reg[7:0]);
                shift_next = shift_reg >> 8;
                if (byte_cnt_reg == BYTE_CNT_W'(RECORD_BYTES - 1))
                begin
                    state_next = ST_ACC;
                end
                else
                begin
                    byte_cnt_next = byte_cnt_reg + 1'b1;
                end
            end
            ST_ACC:
            begin
                if (final_reg)
                begin
                    mul_a_next    = sum_new;
                    mix_next      = xor_new ^ FNV_BASIS;
                    hash_sum_next = '0;
                    hash_xor_next = '0;
                    state_next    = ST_MUL_LL;
                end
                else
                begin
                    hash_sum_next = sum_new;
                    hash_xor_next = xor_new;
                    state_next    = ST_IDLE;
                    start         = head.valid;
                end
            end
            ST_MUL_LL:
            begin
                mul_x      = mul_a_reg[31:0];
                mul_y      = GOLDEN_LO;
                prod_next  = mul_p;
                state_next = ST_MUL_HL;
            end
            ST_MUL_HL:
            begin
                mul_x      = mul_a_reg[63:32];
                mul_y      = GOLDEN_LO;
                prod_next  = prod_reg + {mul_p[31:0], 32'b0};
                state_next = ST_MUL_LH;
            end
            ST_MUL_LH:
            begin
                mul_x      = mul_a_reg[31:0];
                mul_y      = GOLDEN_HI;
                prod_next  = prod_reg + {mul_p[31:0], 32'b0};
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // hold until the previous digest has left the output register
                if (!digest_valid_reg)
                begin
                    set_digest_next   = prod_reg ^ mix_reg;
                    digest_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (start)
        begin
            shift_next    = head.item.record;
            final_next    = head.item.is_final;
            hash_next     = FNV_BASIS;
            byte_cnt_next = '0;
            state_next    = ST_HASH;
        end
    end

    assign pop          = start;
    assign digest_valid = digest_valid_reg;
    assign set_digest   = set_digest_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            byte_cnt_reg     <= '0;
            hash_sum_reg     <= '0;
            hash_xor_reg     <= '0;
            digest_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            byte_cnt_reg     <= byte_cnt_next;
            hash_sum_reg     <= hash_sum_next;
            hash_xor_reg     <= hash_xor_next;
            digest_valid_reg <= digest_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg      <= shift_next;
        hash_reg       <= hash_next;
        final_reg      <= final_next;
        mul_a_reg      <= mul_a_next;
        mix_reg        <= mix_next;
        prod_reg       <= prod_next;
        set_digest_reg <= set_digest_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/order_free_observation_digest.sv =====
// per item: the 56 dependent fnv byte steps through the single multiply-by-prime unit, then
// one accumulate step; after a non-final item the next queued item starts from that step
// a final item then takes three passes of the shared 32x32 multiplier, the output load
// (held while the previous digest is still waiting) and a return to idle
// a two-entry queue takes new items while the hash engine is busy
// reset: rst_n async low, clears queue, accumulators and output valid; no clearing pass
`default_nettype none

module order_free_observation_digest (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        obs_valid,
    output logic             obs_ready,
    input  wire logic [63:0] subject_id,
    input  wire logic [63:0] subject_generation,
    input  wire logic [63:0] served,
    input  wire logic [63:0] unserved_run,
    input  wire logic [63:0] below_floor_run,
    input  wire logic [63:0] priority_ref,
    input  wire logic [63:0] qos_ref,
    input  wire logic        final_item,
    output logic             digest_valid,
    input  wire logic        digest_ready,
    output logic [63:0]      set_digest
);
    import ofod_pkg::*;

    q_head_t head;
    logic    pop;

    ofod_front u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .obs_valid          (obs_valid),
        .obs_ready          (obs_ready),
        .subject_id         (subject_id),
        .subject_generation (subject_generation),
        .served             (served),
        .unserved_run       (unserved_run),
        .below_floor_run    (below_floor_run),
        .priority_ref       (priority_ref),
        .qos_ref            (qos_ref),
        .final_item         (final_item),
        .pop                (pop),
        .head               (head)
    );

    ofod_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .pop          (pop),
        .digest_valid (digest_valid),
        .digest_ready (digest_ready),
        .set_digest   (set_digest)
    );

endmodule

`default_nettype wire

// ===== rtl/core/ofod_checker.sv =====
`default_nettype none

module ofod_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        obs_ready,
    input wire logic        digest_valid,
    input wire logic        digest_ready,
    input wire logic [63:0] set_digest
);

    // a stalled digest holds
    a_digest_hold: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && !digest_ready |=> digest_valid && $stable(set_digest))
        else $error("digest dropped or changed while stalled");

    // no digest once reset has been seen at an edge
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !digest_valid)
        else $error("digest valid during reset");

    // queue is empty straight out of reset
    a_ready_after_reset: assert property (@(posedge clk)
        rst_n && !$past(rst_n) |-> obs_ready)
        else $error("not ready after reset");

    // the output register loads only while empty, so no digest follows a taken one at once
    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && digest_ready |=> !digest_valid)
        else $error("digest right after a taken digest");

endmodule

bind order_free_observation_digest ofod_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .obs_ready    (obs_ready),
    .digest_valid (digest_valid),
    .digest_ready (digest_ready),
    .set_digest   (set_digest)
);

`default_nettype wire
